// ===== src/inverse_adst_8point_top_assert.svh =====
// assertion macros for the inverse adst 8-point block checker
// no dependencies; included by the checker file
`ifndef INVERSE_ADST_8POINT_TOP_ASSERT_SVH
`define INVERSE_ADST_8POINT_TOP_ASSERT_SVH

// condition must never hold outside reset
`define IADST8_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

// antecedent implies consequent (consequent may carry a fixed delay)
`define IADST8_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== src/iadst8_pkg.sv =====
// shared types, cosine constants and fixed-point helpers for the inverse adst 8-point block
// no dependencies; imported by every stage module, the top level and the checker
package iadst8_pkg;

   localparam int unsigned LANES   = 8;
   localparam int unsigned LATENCY = 6;

   typedef logic signed [15:0] samp_type;
   typedef logic signed [31:0] prod_type;
   typedef logic signed [32:0] acc_type;

   // 14-bit cosine constants
   localparam samp_type COS2  = 16'sd16305;
   localparam samp_type COS30 = 16'sd1606;
   localparam samp_type COS10 = 16'sd14449;
   localparam samp_type COS22 = 16'sd7723;
   localparam samp_type COS18 = 16'sd10394;
   localparam samp_type COS14 = 16'sd12665;
   localparam samp_type COS26 = 16'sd4756;
   localparam samp_type COS6  = 16'sd15679;
   localparam samp_type COS8  = 16'sd15137;
   localparam samp_type COS24 = 16'sd6270;
   localparam samp_type COS16 = 16'sd11585;

   function automatic prod_type cmul(samp_type a, samp_type c);
      prod_type ae;
      prod_type ce;
      ae = a;
      ce = c;
      return ae * ce;
   endfunction

   function automatic acc_type add33(prod_type a, prod_type b);
      acc_type ae;
      acc_type be;
      ae = a;
      be = b;
      return ae + be;
   endfunction

   function automatic acc_type sub33(prod_type a, prod_type b);
      acc_type ae;
      acc_type be;
      ae = a;
      be = b;
      return ae - be;
   endfunction

   // add half, arithmetic shift by 14, keep low 16 bits
   function automatic samp_type round14(acc_type v);
      acc_type t;
      t = v + 33'sd8192;
      return t[29:14];
   endfunction

   function automatic samp_type wadd(samp_type a, samp_type b);
      return a + b;
   endfunction

   function automatic samp_type wsub(samp_type a, samp_type b);
      return a - b;
   endfunction

   function automatic samp_type wneg(samp_type a);
      return 16'sd0 - a;
   endfunction

endpackage

// ===== src/iadst8_stage1.sv =====
// first butterfly: input permutation, rotations and rounded cross sums (two register stages)
// depends on iadst8_pkg
module iadst8_stage1
   import iadst8_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  samp_type coef [LANES],
   output logic     out_valid,
   output samp_type x_out [LANES]
);

   logic     prod_valid_ff;
   prod_type s_ff [LANES];
   prod_type s_in [LANES];
   logic     sum_valid_ff;
   samp_type x_ff [LANES];
   samp_type x_in [LANES];
   samp_type p [LANES];

   always_comb begin
      // input permutation
      p[0] = coef[7];
      p[1] = coef[0];
      p[2] = coef[5];
      p[3] = coef[2];
      p[4] = coef[3];
      p[5] = coef[4];
      p[6] = coef[1];
      p[7] = coef[6];

      s_in[0] = cmul(p[0], COS2)  + cmul(p[1], COS30);
      s_in[1] = cmul(p[0], COS30) - cmul(p[1], COS2);
      s_in[2] = cmul(p[2], COS10) + cmul(p[3], COS22);
      s_in[3] = cmul(p[2], COS22) - cmul(p[3], COS10);
      s_in[4] = cmul(p[4], COS18) + cmul(p[5], COS14);
      s_in[5] = cmul(p[4], COS14) - cmul(p[5], COS18);
      s_in[6] = cmul(p[6], COS26) + cmul(p[7], COS6);
      s_in[7] = cmul(p[6], COS6)  - cmul(p[7], COS26);
   end

   always_comb begin
      x_in[0] = round14(add33(s_ff[0], s_ff[4]));
      x_in[1] = round14(add33(s_ff[1], s_ff[5]));
      x_in[2] = round14(add33(s_ff[2], s_ff[6]));
      x_in[3] = round14(add33(s_ff[3], s_ff[7]));
      x_in[4] = round14(sub33(s_ff[0], s_ff[4]));
      x_in[5] = round14(sub33(s_ff[1], s_ff[5]));
      x_in[6] = round14(sub33(s_ff[2], s_ff[6]));
      x_in[7] = round14(sub33(s_ff[3], s_ff[7]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= in_valid;
         sum_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
      x_ff <= x_in;
   end

   assign out_valid = sum_valid_ff;
   assign x_out     = x_ff;

endmodule

// ===== src/iadst8_stage2.sv =====
// second butterfly: wrapped sums on the even half, rotations and rounding on the odd half
// depends on iadst8_pkg
module iadst8_stage2
   import iadst8_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  samp_type x_in_data [LANES],
   output logic     out_valid,
   output samp_type x_out [LANES]
);

   logic     prod_valid_ff;
   samp_type t_ff [4];
   samp_type t_in [4];
   prod_type s_ff [4];
   prod_type s_in [4];
   logic     rnd_valid_ff;
   samp_type y_ff [LANES];
   samp_type y_in [LANES];

   always_comb begin
      t_in[0] = wadd(x_in_data[0], x_in_data[2]);
      t_in[1] = wadd(x_in_data[1], x_in_data[3]);
      t_in[2] = wsub(x_in_data[0], x_in_data[2]);
      t_in[3] = wsub(x_in_data[1], x_in_data[3]);
      // s_in[0..3] hold s4, s5, s6, s7
      s_in[0] = cmul(x_in_data[4], COS8)  + cmul(x_in_data[5], COS24);
      s_in[1] = cmul(x_in_data[4], COS24) - cmul(x_in_data[5], COS8);
      s_in[2] = cmul(x_in_data[7], COS8)  - cmul(x_in_data[6], COS24);
      s_in[3] = cmul(x_in_data[7], COS24) + cmul(x_in_data[6], COS8);
   end

   always_comb begin
      y_in[0] = t_ff[0];
      y_in[1] = t_ff[1];
      y_in[2] = t_ff[2];
      y_in[3] = t_ff[3];
      y_in[4] = round14(add33(s_ff[0], s_ff[2]));
      y_in[5] = round14(add33(s_ff[1], s_ff[3]));
      y_in[6] = round14(sub33(s_ff[0], s_ff[2]));
      y_in[7] = round14(sub33(s_ff[1], s_ff[3]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rnd_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= in_valid;
         rnd_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
      s_ff <= s_in;
      y_ff <= y_in;
   end

   assign out_valid = rnd_valid_ff;
   assign x_out     = y_ff;

endmodule

// ===== src/iadst8_stage3.sv =====
// third butterfly: scale by cospi_16, round, output permutation and negation
// depends on iadst8_pkg
module iadst8_stage3
   import iadst8_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  samp_type x_in_data [LANES],
   output logic     out_valid,
   output samp_type res [LANES]
);

   logic     prod_valid_ff;
   samp_type k_ff [4];
   samp_type k_in [4];
   prod_type p_ff [4];
   prod_type p_in [4];
   logic     res_valid_ff;
   samp_type r_ff [LANES];
   samp_type r_in [LANES];

   always_comb begin
      // pass-through lanes x0, x1, x4, x5
      k_in[0] = x_in_data[0];
      k_in[1] = x_in_data[1];
      k_in[2] = x_in_data[4];
      k_in[3] = x_in_data[5];
      p_in[0] = cmul(wadd(x_in_data[2], x_in_data[3]), COS16);
      p_in[1] = cmul(wsub(x_in_data[2], x_in_data[3]), COS16);
      p_in[2] = cmul(wadd(x_in_data[6], x_in_data[7]), COS16);
      p_in[3] = cmul(wsub(x_in_data[6], x_in_data[7]), COS16);
   end

   always_comb begin
      r_in[0] = k_ff[0];
      r_in[1] = wneg(k_ff[2]);
      r_in[2] = round14(acc_type'(p_ff[2]));
      r_in[3] = wneg(round14(acc_type'(p_ff[0])));
      r_in[4] = round14(acc_type'(p_ff[1]));
      r_in[5] = wneg(round14(acc_type'(p_ff[3])));
      r_in[6] = k_ff[3];
      r_in[7] = wneg(k_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= in_valid;
         res_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      p_ff <= p_in;
      r_ff <= r_in;
   end

   assign out_valid = res_valid_ff;
   assign res       = r_ff;

endmodule

// ===== src/inverse_adst_8point_top.sv =====
// inverse adst 8-point: one 8-coefficient item per cycle through a six-register pipeline
// depends on iadst8_pkg, iadst8_stage1, iadst8_stage2, iadst8_stage3
//
// usage:
//   input: drive req_coef_0..7 and raise start; the item is taken at the clock
//   edge where start is high and busy is low. busy is always low here, so an
//   item may be issued on every cycle.
//   output: the eight transform outputs appear on rsp_res_0..7 for exactly one
//   cycle, flagged by rsp_valid, once the item has passed the six register stages.
//   throughput: one item per cycle; every register stage takes a new item each
//   cycle, each holding either the multiplies and their sum or a wide add and
//   round per lane, so the latency is set by the six stages.
//   items leave in the order they entered; there is no state between items.
//   reset (synchronous, active high) clears every stage valid bit, so items
//   in flight are dropped and nothing is flagged until new items arrive.
//   the receiver has no way to stall; results must be captured when flagged.
module inverse_adst_8point_top
   import iadst8_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic signed [15:0] req_coef_0,
   input  logic signed [15:0] req_coef_1,
   input  logic signed [15:0] req_coef_2,
   input  logic signed [15:0] req_coef_3,
   input  logic signed [15:0] req_coef_4,
   input  logic signed [15:0] req_coef_5,
   input  logic signed [15:0] req_coef_6,
   input  logic signed [15:0] req_coef_7,
   output logic            rsp_valid,
   output logic signed [15:0] rsp_res_0,
   output logic signed [15:0] rsp_res_1,
   output logic signed [15:0] rsp_res_2,
   output logic signed [15:0] rsp_res_3,
   output logic signed [15:0] rsp_res_4,
   output logic signed [15:0] rsp_res_5,
   output logic signed [15:0] rsp_res_6,
   output logic signed [15:0] rsp_res_7
);

   logic     in_valid;
   samp_type coef [LANES];
   logic     s1_valid;
   samp_type s1_data [LANES];
   logic     s2_valid;
   samp_type s2_data [LANES];
   samp_type res [LANES];

   // the pipeline never stalls
   assign busy     = 1'b0;
   assign in_valid = start && !busy;

   always_comb begin
      coef[0] = req_coef_0;
      coef[1] = req_coef_1;
      coef[2] = req_coef_2;
      coef[3] = req_coef_3;
      coef[4] = req_coef_4;
      coef[5] = req_coef_5;
      coef[6] = req_coef_6;
      coef[7] = req_coef_7;
   end

   iadst8_stage1 u_stage1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .coef      (coef),
      .out_valid (s1_valid),
      .x_out     (s1_data)
   );

   iadst8_stage2 u_stage2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .x_in_data (s1_data),
      .out_valid (s2_valid),
      .x_out     (s2_data)
   );

   iadst8_stage3 u_stage3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .x_in_data (s2_data),
      .out_valid (rsp_valid),
      .res       (res)
   );

   assign rsp_res_0 = res[0];
   assign rsp_res_1 = res[1];
   assign rsp_res_2 = res[2];
   assign rsp_res_3 = res[3];
   assign rsp_res_4 = res[4];
   assign rsp_res_5 = res[5];
   assign rsp_res_6 = res[6];
   assign rsp_res_7 = res[7];

endmodule

// ===== src/inverse_adst_8point_top_checker.sv =====
// port-level checker for the inverse adst 8-point block, bound to the top level
// depends on iadst8_pkg and inverse_adst_8point_top_assert.svh
`include "inverse_adst_8point_top_assert.svh"

module inverse_adst_8point_top_checker
   import iadst8_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input logic signed [15:0] req_coef_0,
   input logic signed [15:0] req_coef_1,
   input logic signed [15:0] req_coef_2,
   input logic signed [15:0] req_coef_3,
   input logic signed [15:0] req_coef_4,
   input logic signed [15:0] req_coef_5,
   input logic signed [15:0] req_coef_6,
   input logic signed [15:0] req_coef_7,
   input logic            rsp_valid,
   input logic signed [15:0] rsp_res_0,
   input logic signed [15:0] rsp_res_1,
   input logic signed [15:0] rsp_res_2,
   input logic signed [15:0] rsp_res_3,
   input logic signed [15:0] rsp_res_4,
   input logic signed [15:0] rsp_res_5,
   input logic signed [15:0] rsp_res_6,
   input logic signed [15:0] rsp_res_7
);

   logic accepted;
   logic req_zero;
   logic rsp_zero;

   assign accepted = start && !busy;
   assign req_zero = (req_coef_0 == 16'sd0) && (req_coef_1 == 16'sd0) &&
                     (req_coef_2 == 16'sd0) && (req_coef_3 == 16'sd0) &&
                     (req_coef_4 == 16'sd0) && (req_coef_5 == 16'sd0) &&
                     (req_coef_6 == 16'sd0) && (req_coef_7 == 16'sd0);
   assign rsp_zero = (rsp_res_0 == 16'sd0) && (rsp_res_1 == 16'sd0) &&
                     (rsp_res_2 == 16'sd0) && (rsp_res_3 == 16'sd0) &&
                     (rsp_res_4 == 16'sd0) && (rsp_res_5 == 16'sd0) &&
                     (rsp_res_6 == 16'sd0) && (rsp_res_7 == 16'sd0);

   `IADST8_ASSERT_NEVER(busy_never_high, clock, reset, busy, "busy raised by a non-stalling pipeline")

   `IADST8_ASSERT_IMPLY(item_gives_result, clock, reset, accepted, ##LATENCY rsp_valid, "accepted item produced no result")

   `IADST8_ASSERT_IMPLY(result_has_item, clock, reset, rsp_valid, $past(accepted, LATENCY), "result without a matching item")

   `IADST8_ASSERT_IMPLY(zero_in_zero_out, clock, reset, accepted && req_zero, ##LATENCY rsp_zero, "all-zero item gave a nonzero result")

endmodule

bind inverse_adst_8point_top inverse_adst_8point_top_checker u_checker (.*);

// ===== sim/tb.sv =====
// testbench for inverse_adst_8point_top: directed edge items, random bursts and a streaming run
// each result is checked against a bit-true 8-point inverse adst predictor
// depends on iadst8_pkg and the inverse_adst_8point_top rtl
`timescale 1ns / 1ps

module tb;
   import iadst8_pkg::*;

   typedef logic [7:0][15:0] row_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [15:0] req_coef_0, req_coef_1, req_coef_2, req_coef_3;
   logic signed [15:0] req_coef_4, req_coef_5, req_coef_6, req_coef_7;
   logic rsp_valid;
   logic signed [15:0] rsp_res_0, rsp_res_1, rsp_res_2, rsp_res_3;
   logic signed [15:0] rsp_res_4, rsp_res_5, rsp_res_6, rsp_res_7;

   row_type expected_rows[$];
   int items_sent;
   int rows_checked;
   int mismatch_count;
   int stray_results;

   inverse_adst_8point_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_coef_0 (req_coef_0),
      .req_coef_1 (req_coef_1),
      .req_coef_2 (req_coef_2),
      .req_coef_3 (req_coef_3),
      .req_coef_4 (req_coef_4),
      .req_coef_5 (req_coef_5),
      .req_coef_6 (req_coef_6),
      .req_coef_7 (req_coef_7),
      .rsp_valid  (rsp_valid),
      .rsp_res_0  (rsp_res_0),
      .rsp_res_1  (rsp_res_1),
      .rsp_res_2  (rsp_res_2),
      .rsp_res_3  (rsp_res_3),
      .rsp_res_4  (rsp_res_4),
      .rsp_res_5  (rsp_res_5),
      .rsp_res_6  (rsp_res_6),
      .rsp_res_7  (rsp_res_7)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("tb: timeout with %0d results outstanding", expected_rows.size());
      $display("tb: done, errors");
      $finish;
   end

   // keep the low 16 bits, sign-extended
   function automatic longint wrap16(longint v);
      return longint'($signed(v[15:0]));
   endfunction

   function automatic longint q14_round(longint v);
      longint t;
      t = (v + 64'sd8192) >>> 14;
      return wrap16(t);
   endfunction

   function automatic row_type adst8_predict(row_type c);
      longint a0, a1, a2, a3, a4, a5, a6, a7;
      longint p0, p1, p2, p3, p4, p5, p6, p7;
      longint h0, h1, h2, h3, sm, df;
      row_type r;
      // input permutation
      a0 = longint'($signed(c[7]));
      a1 = longint'($signed(c[0]));
      a2 = longint'($signed(c[5]));
      a3 = longint'($signed(c[2]));
      a4 = longint'($signed(c[3]));
      a5 = longint'($signed(c[4]));
      a6 = longint'($signed(c[1]));
      a7 = longint'($signed(c[6]));

      p0 = COS2 * a0 + COS30 * a1;
      p1 = COS30 * a0 - COS2 * a1;
      p2 = COS10 * a2 + COS22 * a3;
      p3 = COS22 * a2 - COS10 * a3;
      p4 = COS18 * a4 + COS14 * a5;
      p5 = COS14 * a4 - COS18 * a5;
      p6 = COS26 * a6 + COS6 * a7;
      p7 = COS6 * a6 - COS26 * a7;
      a0 = q14_round(p0 + p4);
      a1 = q14_round(p1 + p5);
      a2 = q14_round(p2 + p6);
      a3 = q14_round(p3 + p7);
      a4 = q14_round(p0 - p4);
      a5 = q14_round(p1 - p5);
      a6 = q14_round(p2 - p6);
      a7 = q14_round(p3 - p7);

      h0 = a0; h1 = a1; h2 = a2; h3 = a3;
      p4 = COS8 * a4 + COS24 * a5;
      p5 = COS24 * a4 - COS8 * a5;
      p7 = COS24 * a7 + COS8 * a6;
      p6 = COS8 * a7 - COS24 * a6;
      a0 = wrap16(h0 + h2);
      a1 = wrap16(h1 + h3);
      a2 = wrap16(h0 - h2);
      a3 = wrap16(h1 - h3);
      a4 = q14_round(p4 + p6);
      a5 = q14_round(p5 + p7);
      a6 = q14_round(p4 - p6);
      a7 = q14_round(p5 - p7);

      sm = wrap16(a2 + a3);
      df = wrap16(a2 - a3);
      a2 = q14_round(COS16 * sm);
      a3 = q14_round(COS16 * df);
      sm = wrap16(a6 + a7);
      df = wrap16(a6 - a7);
      a6 = q14_round(COS16 * sm);
      a7 = q14_round(COS16 * df);

      // output permutation, four lanes negated with wrap
      r[0] = a0[15:0];
      r[1] = 16'(-a4);
      r[2] = a6[15:0];
      r[3] = 16'(-a2);
      r[4] = a3[15:0];
      r[5] = 16'(-a7);
      r[6] = a5[15:0];
      r[7] = 16'(-a1);
      return r;
   endfunction

   // biased toward the range limits so wrap cases come up often
   function automatic logic [15:0] pick_coef();
      logic [15:0] v;
      case ($urandom_range(0, 7))
         0: v = 16'h8000;
         1: v = 16'h7fff;
         2: v = 16'($urandom_range(0, 64)) - 16'd32;
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   function automatic row_type pick_row();
      row_type r;
      for (int i = 0; i < 8; i++) r[i] = pick_coef();
      return r;
   endfunction

   // called right after a rising edge; returns at the edge that took the item
   task automatic send_row(input row_type c);
      start      <= 1'b1;
      req_coef_0 <= c[0];
      req_coef_1 <= c[1];
      req_coef_2 <= c[2];
      req_coef_3 <= c[3];
      req_coef_4 <= c[4];
      req_coef_5 <= c[5];
      req_coef_6 <= c[6];
      req_coef_7 <= c[7];
      do @(posedge clock); while (busy);
      expected_rows.push_back(adst8_predict(c));
      items_sent++;
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_rows.size() != 0);
   endtask

   task automatic test_directed_edges();
      row_type r;
      send_row('0);
      send_row({8{16'h7fff}});
      send_row({8{16'h8000}});
      send_row({8{16'hffff}});
      send_row({4{16'h7fff, 16'h8000}});
      send_row({4{16'h8000, 16'h7fff}});
      // single-coefficient impulses at both limits
      for (int i = 0; i < 8; i++) begin
         r = '0;
         r[i] = 16'h7fff;
         send_row(r);
         r[i] = 16'h8000;
         send_row(r);
      end
      wait_all_results();
   endtask

   task automatic test_random_bursts(input int count);
      int burst;
      int done;
      done = 0;
      while (done < count) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && done < count; k++) begin
            send_row(pick_row());
            done++;
            if ($urandom_range(0, 15) == 0) hold_off($urandom_range(1, 3));
         end
         if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
      end
      wait_all_results();
   endtask

   task automatic test_streaming(input int count);
      for (int k = 0; k < count; k++) send_row(pick_row());
      wait_all_results();
   endtask

   always @(posedge clock) begin
      row_type got;
      row_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_res_7, rsp_res_6, rsp_res_5, rsp_res_4,
                rsp_res_3, rsp_res_2, rsp_res_1, rsp_res_0};
         if (expected_rows.size() == 0) begin
            stray_results++;
            $display("tb: result with no item outstanding");
         end else begin
            want = expected_rows.pop_front();
            rows_checked++;
            for (int i = 0; i < 8; i++) begin
               if (got[i] !== want[i]) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("tb: result %0d res_%0d expected %0d got %0d",
                              rows_checked, i, $signed(want[i]), $signed(got[i]));
               end
            end
         end
      end
   end

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_coef_0 = '0;
      req_coef_1 = '0;
      req_coef_2 = '0;
      req_coef_3 = '0;
      req_coef_4 = '0;
      req_coef_5 = '0;
      req_coef_6 = '0;
      req_coef_7 = '0;
      items_sent     = 0;
      rows_checked   = 0;
      mismatch_count = 0;
      stray_results  = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_edges();
      test_random_bursts(1300);
      test_streaming(200);

      repeat (LATENCY + 4) @(posedge clock);
      $display("tb: %0d items sent (edges, random bursts, back-to-back stream), %0d checked",
               items_sent, rows_checked);
      $display("tb: %0d field mismatches, %0d unexpected results, %0d missing",
               mismatch_count, stray_results, expected_rows.size());
      if (mismatch_count == 0 && stray_results == 0 && expected_rows.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== inverse_adst_8point_top.f =====
+incdir+src
src/iadst8_pkg.sv
src/iadst8_stage1.sv
src/iadst8_stage2.sv
src/iadst8_stage3.sv
src/inverse_adst_8point_top.sv
src/inverse_adst_8point_top_checker.sv
sim/tb.sv
